>>> rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

    // Request codes carried in the low bits of the input tdata
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    localparam int WORD_W = 64;
    localparam int OP_W   = 3;

endpackage

>>> rtl/dq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue over a ring store.
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  op, value
//  m_axis    out  m_tvalid/m_tready  front_value, back_value, count, empty_res, status
//
// Each request passes S_IDLE, which moves the end pointers and writes a pushed
// word or issues the read of the new end after a pop, then S_RESULT, which takes
// the registered read data of the word RAM and loads the result register. Both
// end words are cached in registers, so only a pop needs the read port. Reset
// clears pointers, count and direction; the store is never cleared, and stale
// reads never reach the result. A stalled result holds the input side off.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,  // op[2:0], value[66:3]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // front_value, back_value, count, empty_res, status
    output logic [((128+$clog2(DEPTH+1)+3+7)/8)*8-1:0] m_tdata
);

    import dq_pkg::*;

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_B = 2*WORD_W + CW + 3;
    localparam int OUT_W = ((OUT_B + 7) / 8) * 8;

    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
        return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
        return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
    endfunction

    state_t              state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rev_reg, rev_next;
    logic [WORD_W-1:0]   left_reg, left_next;
    logic [WORD_W-1:0]   right_reg, right_next;
    logic                pend_left_reg, pend_left_next;
    logic                pend_right_reg, pend_right_next;
    status_t             status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                accept;
    logic                load_out;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [IW-1:0]       rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [OP_W-1:0]     in_op;
    logic [WORD_W-1:0]   in_value;
    logic                is_full;
    logic                is_empty;
    logic                to_left;
    logic [WORD_W-1:0]   left_eff;
    logic [WORD_W-1:0]   right_eff;
    logic [WORD_W-1:0]   front_word;
    logic [WORD_W-1:0]   back_word;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W+WORD_W-1:OP_W];
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
            end
            S_RESULT:
            begin
                load_out = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Pointer update, store access and end-word cache
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        pend_left_next  = pend_left_reg;
        pend_right_next = pend_right_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        rd_addr         = idx_next(head_reg);
        to_left         = 1'b0;

        left_eff  = pend_left_reg ? rd_data : left_reg;
        right_eff = pend_right_reg ? rd_data : right_reg;

        if (accept)
        begin
            status_next     = ST_OK;
            pend_left_next  = 1'b0;
            pend_right_next = 1'b0;
            case (op_t'(in_op))
                OP_PUSH_BACK, OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        to_left = (op_t'(in_op) == OP_PUSH_BACK) ? rev_reg : !rev_reg;
                        wr_en   = 1'b1;
                        if (to_left)
                        begin
                            head_next = idx_prev(head_reg);
                            wr_addr   = idx_prev(head_reg);
                            left_next = in_value;
                            if (is_empty)
                            begin
                                right_next = in_value;
                            end
                        end
                        else
                        begin
                            wr_addr    = tail_reg;
                            tail_next  = idx_next(tail_reg);
                            right_next = in_value;
                            if (is_empty)
                            begin
                                left_next = in_value;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        to_left = (op_t'(in_op) == OP_POP_FRONT) ? !rev_reg : rev_reg;
                        if (to_left)
                        begin
                            head_next      = idx_next(head_reg);
                            rd_addr        = idx_next(head_reg);
                            pend_left_next = 1'b1;
                        end
                        else
                        begin
                            tail_next       = idx_prev(tail_reg);
                            rd_addr         = idx_prev(idx_prev(tail_reg));
                            pend_right_next = 1'b1;
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (load_out)
        begin
            // take the refetched end word from the store
            left_next       = left_eff;
            right_next      = right_eff;
            pend_left_next  = 1'b0;
            pend_right_next = 1'b0;
        end
    end

    // Result word
    always_comb
    begin
        front_word = '0;
        back_word  = '0;
        if (!is_empty)
        begin
            front_word = rev_reg ? right_eff : left_eff;
            back_word  = rev_reg ? left_eff : right_eff;
        end
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out)
        begin
            out_data_next  = OUT_W'({status_reg, is_empty, count_reg, back_word, front_word});
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            pend_left_reg  <= 1'b0;
            pend_right_reg <= 1'b0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            rev_reg        <= rev_next;
            pend_left_reg  <= pend_left_next;
            pend_right_reg <= pend_right_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
